@@ rtl/core/ema_filter_with_timeout_reinit_core_defines.svh @@
// Assertion macros shared by the EMA filter core.
`ifndef EMA_FILTER_WITH_TIMEOUT_REINIT_CORE_DEFINES_SVH
`define EMA_FILTER_WITH_TIMEOUT_REINIT_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define EMAF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define EMAF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/emaf_pkg.sv @@
// Types and constants shared by the EMA filter core.
`default_nettype none
package emaf_pkg;

	localparam int SAMPLE_W  = 32;
	localparam int FRAC_W    = 16;
	localparam int ALPHA_W   = 17;
	localparam int TICK_W    = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;
	localparam int NUM_LANES = 4;

	localparam logic [ALPHA_W-1:0] ONE_Q16     = ALPHA_W'(1) << FRAC_W;
	localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(1) << (FRAC_W - 1);

	localparam logic [CFG_IDX_W-1:0] REG_ALPHA   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = CFG_IDX_W'(1);

	typedef enum logic [1:0] {
		OP_TICK   = 2'd0,
		OP_SCALAR = 2'd1,
		OP_VECTOR = 2'd2,
		OP_RESET  = 2'd3
	} op_t;

	typedef struct packed {
		op_t                        opcode;
		logic signed [SAMPLE_W-1:0] sample_a;
		logic signed [SAMPLE_W-1:0] sample_b;
		logic signed [SAMPLE_W-1:0] sample_c;
	} sample_word_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] scalar_avg;
		logic signed [SAMPLE_W-1:0] avg_x;
		logic signed [SAMPLE_W-1:0] avg_y;
		logic signed [SAMPLE_W-1:0] avg_z;
		logic                       scalar_valid;
		logic                       vector_valid;
	} result_word_t;

	// per-lane control: en updates the accumulator, load replaces it with the sample
	typedef struct packed {
		logic en;
		logic load;
	} lane_ctl_t;

	typedef struct packed {
		logic out_full;
		logic skid_full;
	} buf_stat_t;

endpackage
`default_nettype wire

@@ rtl/core/emaf_lane.sv @@
// One accumulator lane: loads or blends a sample into its running average.
`default_nettype none
module emaf_lane (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  emaf_pkg::lane_ctl_t                 ctl,
	input  wire  [emaf_pkg::ALPHA_W-1:0]        alpha,
	input  wire  signed [emaf_pkg::SAMPLE_W-1:0] x,
	output logic signed [emaf_pkg::SAMPLE_W-1:0] acc_nxt
);
	import emaf_pkg::*;

	localparam int PROD_W = SAMPLE_W + ALPHA_W + 1;

	logic signed [SAMPLE_W-1:0] acc_q;
	logic signed [SAMPLE_W:0]   diff;
	logic signed [ALPHA_W:0]    alpha_s;
	logic signed [PROD_W-1:0]   prod;
	logic signed [SAMPLE_W-1:0] acc_upd;

	// acc + floor(alpha*(x-acc)/2^16) equals the floored convex blend
	assign diff    = {x[SAMPLE_W-1], x} - {acc_q[SAMPLE_W-1], acc_q};
	assign alpha_s = signed'({1'b0, alpha});
	assign prod    = PROD_W'(alpha_s) * PROD_W'(diff);
	assign acc_upd = acc_q + signed'(prod[SAMPLE_W+FRAC_W-1:FRAC_W]);

	always_comb begin
		if (!ctl.en) begin
			acc_nxt = acc_q;
		end else if (ctl.load) begin
			acc_nxt = x;
		end else begin
			acc_nxt = acc_upd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.en) begin
			acc_q <= acc_nxt;
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/emaf_outbuf.sv @@
// Merge stage: gathers lane results into one word and buffers it two deep.
`default_nettype none
module emaf_outbuf (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   push,
	input  wire  signed [emaf_pkg::SAMPLE_W-1:0]  lane_acc [emaf_pkg::NUM_LANES],
	input  wire                                   scalar_flag,
	input  wire                                   vector_flag,
	output emaf_pkg::result_word_t                result_word,
	output logic                                  result_valid,
	input  wire                                   result_ready,
	output emaf_pkg::buf_stat_t                   stat
);
	import emaf_pkg::*;

	result_word_t merged;
	result_word_t out_q;
	result_word_t skid_q;
	logic         out_vld_q;
	logic         skid_vld_q;
	logic         out_free;

	always_comb begin
		merged.scalar_avg   = lane_acc[0];
		merged.avg_x        = lane_acc[1];
		merged.avg_y        = lane_acc[2];
		merged.avg_z        = lane_acc[3];
		merged.scalar_valid = scalar_flag;
		merged.vector_valid = vector_flag;
	end

	assign out_free = !out_vld_q || result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (out_free) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= push;
			end else begin
				out_vld_q  <= push;
			end
		end else if (push) begin
			skid_vld_q <= 1'b1;
		end
	end

	// payload: advance skid into the output slot, park new words behind it
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_vld_q) begin
				out_q <= skid_q;
				if (push) begin
					skid_q <= merged;
				end
			end else if (push) begin
				out_q <= merged;
			end
		end else if (push) begin
			skid_q <= merged;
		end
	end

	assign result_word    = out_q;
	assign result_valid   = out_vld_q;
	assign stat.out_full  = out_vld_q;
	assign stat.skid_full = skid_vld_q;

endmodule
`default_nettype wire

@@ rtl/core/ema_filter_with_timeout_reinit_core.sv @@
// EMA filter core: one scalar and three vector lanes with tick-based timeout reinit.
// Results: each result word is registered in the output slot, or parked in the skid slot under stall.
// Throughput: one word per clock while the skid slot is empty; each lane's combinational multiply-add
// closes the accumulator loop, and a two-entry output buffer keeps input open under stall until the skid slot fills.
// Reset: averages, flags and tick count clear; alpha returns to 0.5, timeout to off.
`default_nettype none
`include "ema_filter_with_timeout_reinit_core_defines.svh"
module ema_filter_with_timeout_reinit_core (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  cfg_valid,
	output logic                                 cfg_ready,
	input  wire  [emaf_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire  [emaf_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  wire                                  sample_valid,
	output logic                                 sample_ready,
	input  emaf_pkg::sample_word_t               sample_word,
	output logic                                 result_valid,
	input  wire                                  result_ready,
	output emaf_pkg::result_word_t               result_word
);
	import emaf_pkg::*;

	logic [ALPHA_W-1:0]  alpha_q;
	logic [TICK_W-1:0]   timeout_q;
	logic [TICK_W-1:0]   ticks_q;
	logic                scalar_rdy_q;
	logic                vector_rdy_q;
	logic                scalar_rdy_nxt;
	logic                vector_rdy_nxt;
	logic                push;
	logic                timed_out;
	logic                scalar_live;
	logic                vector_live;
	lane_ctl_t           lane_ctl [NUM_LANES];
	logic signed [SAMPLE_W-1:0] lane_x   [NUM_LANES];
	logic signed [SAMPLE_W-1:0] lane_acc [NUM_LANES];
	buf_stat_t           stat;
	logic [ALPHA_W-1:0]  cfg_alpha;

	assign cfg_ready    = 1'b1;
	assign sample_ready = !stat.skid_full;
	assign push         = sample_valid && sample_ready;

	// clamp alpha above 1.0 on write
	assign cfg_alpha = (cfg_data[ALPHA_W-1:0] > ONE_Q16) ? ONE_Q16 : cfg_data[ALPHA_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q   <= ALPHA_RESET;
			timeout_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ALPHA:   alpha_q   <= cfg_alpha;
				REG_TIMEOUT: timeout_q <= cfg_data[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	assign timed_out   = (timeout_q != '0) && (ticks_q >= timeout_q);
	assign scalar_live = scalar_rdy_q && !timed_out;
	assign vector_live = vector_rdy_q && !timed_out;

	always_comb begin
		scalar_rdy_nxt = scalar_rdy_q;
		vector_rdy_nxt = vector_rdy_q;
		for (int i = 0; i < NUM_LANES; i++) begin
			lane_ctl[i].en   = 1'b0;
			lane_ctl[i].load = 1'b0;
		end
		unique case (sample_word.opcode)
			OP_TICK: begin
			end
			OP_SCALAR: begin
				lane_ctl[0].en   = push;
				lane_ctl[0].load = !scalar_live;
				scalar_rdy_nxt   = 1'b1;
				vector_rdy_nxt   = vector_live;
			end
			OP_VECTOR: begin
				for (int i = 1; i < NUM_LANES; i++) begin
					lane_ctl[i].en   = push;
					lane_ctl[i].load = !vector_live;
				end
				scalar_rdy_nxt = scalar_live;
				vector_rdy_nxt = 1'b1;
			end
			OP_RESET: begin
				scalar_rdy_nxt = 1'b0;
				vector_rdy_nxt = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scalar_rdy_q <= 1'b0;
			vector_rdy_q <= 1'b0;
			ticks_q      <= '0;
		end else if (push) begin
			scalar_rdy_q <= scalar_rdy_nxt;
			vector_rdy_q <= vector_rdy_nxt;
			unique case (sample_word.opcode)
				OP_TICK: begin
					// saturate
					if (ticks_q != '1) begin
						ticks_q <= ticks_q + TICK_W'(1);
					end
				end
				OP_SCALAR, OP_VECTOR: ticks_q <= '0;
				OP_RESET: ;
			endcase
		end
	end

	assign lane_x[0] = sample_word.sample_a;
	assign lane_x[1] = sample_word.sample_a;
	assign lane_x[2] = sample_word.sample_b;
	assign lane_x[3] = sample_word.sample_c;

	for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
		emaf_lane u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (lane_ctl[g]),
			.alpha   (alpha_q),
			.x       (lane_x[g]),
			.acc_nxt (lane_acc[g])
		);
	end

	emaf_outbuf u_outbuf (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.lane_acc     (lane_acc),
		.scalar_flag  (scalar_rdy_nxt),
		.vector_flag  (vector_rdy_nxt),
		.result_word  (result_word),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.stat         (stat)
	);

	`EMAF_ASSERT_NOW(a_skid_behind_out, stat.skid_full, stat.out_full, "skid word without output word")
	`EMAF_ASSERT_NEXT(a_tick_saturates, push && sample_word.opcode == OP_TICK && ticks_q == '1, ticks_q == '1, "tick count wrapped")
	`EMAF_ASSERT_NEXT(a_scalar_sets_flag, push && sample_word.opcode == OP_SCALAR, scalar_rdy_q && ticks_q == '0, "scalar sample left flag or ticks wrong")
	`EMAF_ASSERT_NEXT(a_timeout_clears, push && sample_word.opcode == OP_VECTOR && timed_out, !scalar_rdy_q && vector_rdy_q, "timeout did not reinit scalar channel")

endmodule
`default_nettype wire

@@ bench/ema_tracker_pkg.sv @@
// Expected-result tracker for the EMA filter bench: shadow filter state plus result queue.
package ema_tracker_pkg;
	import emaf_pkg::*;

	class ema_tracker;
		logic [ALPHA_W-1:0]         alpha;
		logic [TICK_W-1:0]          timeout;
		logic signed [SAMPLE_W-1:0] scalar_acc;
		logic signed [SAMPLE_W-1:0] vec_acc [3];
		bit                         scalar_init;
		bit                         vector_init;
		logic [TICK_W-1:0]          idle_ticks;
		result_word_t               expected_avgs[$];
		int                         errors;

		function new();
			alpha = ALPHA_RESET;
			timeout = '0;
			scalar_acc = '0;
			foreach (vec_acc[i]) vec_acc[i] = '0;
			scalar_init = 1'b0;
			vector_init = 1'b0;
			idle_ticks = '0;
			errors = 0;
		endfunction

		function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_ALPHA: alpha = data[ALPHA_W-1:0];
				REG_TIMEOUT: timeout = data[TICK_W-1:0];
				default: ;
			endcase
		endfunction

		// floored (a*x + (1-a)*acc), all in Q16
		function logic signed [SAMPLE_W-1:0] blend_q16(input logic signed [SAMPLE_W-1:0] x,
				input logic signed [SAMPLE_W-1:0] acc, input logic [ALPHA_W-1:0] a);
			longint wa;
			longint wb;
			longint sum;
			wa = a;
			wb = longint'(ONE_Q16) - wa;
			sum = wa * longint'(x) + wb * longint'(acc);
			return SAMPLE_W'(sum >>> FRAC_W);
		endfunction

		function void drop_on_timeout();
			if (timeout != '0 && idle_ticks >= timeout) begin
				scalar_init = 1'b0;
				vector_init = 1'b0;
			end
		endfunction

		function void note_word(input sample_word_t w);
			logic [ALPHA_W-1:0] a;
			result_word_t r;
			a = (alpha > ONE_Q16) ? ONE_Q16 : alpha;
			case (w.opcode)
				OP_TICK: begin
					if (idle_ticks != '1) idle_ticks = idle_ticks + 1'b1;
				end
				OP_SCALAR: begin
					drop_on_timeout();
					if (scalar_init) begin
						scalar_acc = blend_q16(w.sample_a, scalar_acc, a);
					end else begin
						scalar_acc = w.sample_a;
						scalar_init = 1'b1;
					end
					idle_ticks = '0;
				end
				OP_VECTOR: begin
					drop_on_timeout();
					if (vector_init) begin
						vec_acc[0] = blend_q16(w.sample_a, vec_acc[0], a);
						vec_acc[1] = blend_q16(w.sample_b, vec_acc[1], a);
						vec_acc[2] = blend_q16(w.sample_c, vec_acc[2], a);
					end else begin
						vec_acc[0] = w.sample_a;
						vec_acc[1] = w.sample_b;
						vec_acc[2] = w.sample_c;
					end
					vector_init = 1'b1;
					idle_ticks = '0;
				end
				OP_RESET: begin
					scalar_init = 1'b0;
					vector_init = 1'b0;
				end
				default: ;
			endcase
			r.scalar_avg = scalar_acc;
			r.avg_x = vec_acc[0];
			r.avg_y = vec_acc[1];
			r.avg_z = vec_acc[2];
			r.scalar_valid = scalar_init;
			r.vector_valid = vector_init;
			expected_avgs.push_back(r);
		endfunction

		function void cmp_field(input string name, input logic signed [SAMPLE_W-1:0] want,
				input logic signed [SAMPLE_W-1:0] got);
			if (got !== want) begin
				$error("%s mismatch: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_word(input result_word_t got);
			result_word_t want;
			if (expected_avgs.size() == 0) begin
				$error("result word arrived with nothing expected");
				errors++;
				return;
			end
			want = expected_avgs.pop_front();
			cmp_field("scalar_avg", want.scalar_avg, got.scalar_avg);
			cmp_field("avg_x", want.avg_x, got.avg_x);
			cmp_field("avg_y", want.avg_y, got.avg_y);
			cmp_field("avg_z", want.avg_z, got.avg_z);
			cmp_field("scalar_valid", want.scalar_valid, got.scalar_valid);
			cmp_field("vector_valid", want.vector_valid, got.vector_valid);
		endfunction

		function int pending();
			return expected_avgs.size();
		endfunction
	endclass
endpackage

@@ bench/tb_top.sv @@
// Top-level bench for the EMA filter core: directed and random sample streams, config sweeps.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import emaf_pkg::*;
	import ema_tracker_pkg::*;

	typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_t;

	localparam logic signed [SAMPLE_W-1:0] S_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [SAMPLE_W-1:0] S_MIN = 32'sh8000_0000;
	localparam int RX_HOLD_CYCLES = 300;
	localparam int RAND_PHASES    = 6;
	localparam int PHASE_ITEMS    = 180;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  sample_valid = 1'b0;
	logic                  sample_ready;
	sample_word_t          sample_word = '0;
	logic                  result_valid;
	logic                  result_ready = 1'b0;
	result_word_t          result_word;
	int                    hold_reqs = 0;

	ema_tracker avgs = new();

	ema_filter_with_timeout_reinit_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample_word  (sample_word),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_word  (result_word)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("TEST FAILED");
		$finish;
	end

	function automatic sample_word_t mk(input op_t op, input logic signed [SAMPLE_W-1:0] a,
			input logic signed [SAMPLE_W-1:0] b, input logic signed [SAMPLE_W-1:0] c);
		sample_word_t w;
		w.opcode = op;
		w.sample_a = a;
		w.sample_b = b;
		w.sample_c = c;
		return w;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] rand_sample();
		int k;
		k = $urandom_range(0, 9);
		case (k)
			0: return S_MAX;
			1: return S_MIN;
			2: return SAMPLE_W'(int'($urandom_range(0, 32'h3FFFF)) - 32'h20000);
			default: return $urandom();
		endcase
	endfunction

	function automatic sample_word_t rand_word();
		int r;
		op_t op;
		r = $urandom_range(0, 99);
		if (r < 40) op = OP_TICK;
		else if (r < 68) op = OP_SCALAR;
		else if (r < 94) op = OP_VECTOR;
		else op = OP_RESET;
		return mk(op, rand_sample(), rand_sample(), rand_sample());
	endfunction

	function automatic logic [CFG_DATA_W-1:0] rand_alpha();
		logic [ALPHA_W-1:0] a;
		logic [CFG_DATA_W-ALPHA_W-1:0] junk;
		case ($urandom_range(0, 7))
			0: a = '0;
			1: a = ALPHA_W'(1);
			2: a = ONE_Q16;
			3: a = ONE_Q16 + 1'b1;
			4: a = '1;
			5: a = ALPHA_W'(16'hFFFF);
			default: a = ALPHA_W'($urandom());
		endcase
		// upper bits are outside the register
		junk = $urandom_range(0, 1) ? (CFG_DATA_W-ALPHA_W)'($urandom()) : '0;
		return {junk, a};
	endfunction

	function automatic logic [CFG_DATA_W-1:0] rand_timeout();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return $urandom();
			default: return $urandom_range(1, 8);
		endcase
	endfunction

	task automatic push_word(input sample_word_t w);
		sample_valid <= 1'b1;
		sample_word <= w;
		@(posedge clk);
		while (!sample_ready) @(posedge clk);
		avgs.note_word(w);
	endtask

	task automatic pause_sender(input int n);
		sample_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// write both registers once the filter has drained
	task automatic configure(input logic [CFG_DATA_W-1:0] alpha_data,
			input logic [CFG_DATA_W-1:0] timeout_data);
		logic [CFG_IDX_W-1:0]  idx [2];
		logic [CFG_DATA_W-1:0] data [2];
		idx[0] = REG_ALPHA;
		idx[1] = REG_TIMEOUT;
		data[0] = alpha_data;
		data[1] = timeout_data;
		sample_valid <= 1'b0;
		while (avgs.pending() != 0) @(posedge clk);
		for (int i = 0; i < 2; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= data[i];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			avgs.write_reg(idx[i], data[i]);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic directed_part();
		// reset defaults: first loads, floor on blends, flag clear
		push_word(mk(OP_TICK, S_MAX, S_MIN, 0));
		push_word(mk(OP_SCALAR, S_MAX, 0, 0));
		push_word(mk(OP_SCALAR, S_MIN, 0, 0));
		push_word(mk(OP_VECTOR, S_MAX, S_MIN, 0));
		push_word(mk(OP_VECTOR, S_MIN, S_MAX, -1));
		push_word(mk(OP_RESET, 1, 2, 3));
		push_word(mk(OP_SCALAR, 32'sh0001_8000, S_MAX, S_MIN));
		push_word(mk(OP_VECTOR, 32'sh0001_0000, -32'sh0001_0000, S_MAX));
		configure(32'd0, 32'd0);
		push_word(mk(OP_SCALAR, S_MAX, 0, 0));
		push_word(mk(OP_VECTOR, S_MIN, S_MIN, S_MIN));
		configure(CFG_DATA_W'(ONE_Q16), 32'd0);
		push_word(mk(OP_SCALAR, S_MIN, 0, 0));
		push_word(mk(OP_VECTOR, 1, 2, 3));
		// alpha above one, with bits past the register width
		configure(32'hFFFF_FFFF, 32'd0);
		push_word(mk(OP_SCALAR, -32'sh0001_0000, 0, 0));
		configure(32'd1, 32'd0);
		push_word(mk(OP_SCALAR, S_MAX, 0, 0));
		// timeout of three: two ticks keep flags, three clear both channels
		configure(CFG_DATA_W'(ALPHA_RESET), 32'd3);
		push_word(mk(OP_TICK, 0, 0, 0));
		push_word(mk(OP_TICK, 0, 0, 0));
		push_word(mk(OP_SCALAR, 5, 0, 0));
		push_word(mk(OP_TICK, 0, 0, 0));
		push_word(mk(OP_TICK, 0, 0, 0));
		push_word(mk(OP_TICK, 0, 0, 0));
		push_word(mk(OP_VECTOR, 7, 8, 9));
		configure(CFG_DATA_W'(ALPHA_RESET), 32'hFFFF_FFFF);
		push_word(mk(OP_TICK, 0, 0, 0));
		push_word(mk(OP_SCALAR, -1, 0, 0));
	endtask

	task automatic random_part();
		int burst_left;
		int gap;
		burst_left = 0;
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			configure(rand_alpha(), rand_timeout());
			if (ph == 0 || ph == RAND_PHASES / 2) hold_reqs <= hold_reqs + 1;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (burst_left == 0) begin
					gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					if (gap > 0) pause_sender(gap);
					burst_left = $urandom_range(1, 40);
				end
				burst_left--;
				push_word(rand_word());
			end
		end
	endtask

	// result side: check accepted words, stall on a pattern of its own
	initial begin
		rx_mode_t mode;
		int left;
		int hold_left;
		int served;
		mode = RX_OPEN;
		left = 0;
		hold_left = 0;
		served = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (result_valid && result_ready) avgs.check_word(result_word);
			if (served != hold_reqs) begin
				served = hold_reqs;
				hold_left = RX_HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else begin
				if (left == 0) begin
					mode = rx_mode_t'($urandom_range(0, 3));
					left = $urandom_range(10, 80);
				end
				left--;
				case (mode)
					RX_OPEN: result_ready <= 1'b1;
					RX_COIN: result_ready <= $urandom_range(0, 1);
					RX_SPARSE: result_ready <= ($urandom_range(0, 3) == 0);
					default: result_ready <= ~result_ready;
				endcase
			end
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		directed_part();
		random_part();
		sample_valid <= 1'b0;
		while (avgs.pending() != 0) @(posedge clk);
		// catch any stray word after the last one
		repeat (4) @(posedge clk);
		if (avgs.errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule

@@ ema_filter_with_timeout_reinit_core.f @@
+incdir+rtl/core
rtl/core/emaf_pkg.sv
rtl/core/emaf_lane.sv
rtl/core/emaf_outbuf.sv
rtl/core/ema_filter_with_timeout_reinit_core.sv
bench/ema_tracker_pkg.sv
bench/tb_top.sv
